// ===== rtl/core/trc_pkg.sv =====
`default_nettype none
package trc_pkg;

  localparam int PC_W   = 11;
  localparam int CYC_W  = 14;
  localparam int WORD_W = 16;

  // unified memory size and its address width
  localparam int MEM_WORDS = 1024;
  localparam int AW        = 10;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_EXIT  = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_INT   = 3'd1;
  localparam logic [2:0] EV_NL    = 3'd2;
  localparam logic [2:0] EV_STR   = 3'd3;
  localparam logic [2:0] EV_BAD   = 3'd4;

  localparam logic [5:0] OP_ADD = 6'd0;
  localparam logic [5:0] OP_SUB = 6'd1;
  localparam logic [5:0] OP_MUL = 6'd2;
  localparam logic [5:0] OP_DIV = 6'd3;
  localparam logic [5:0] OP_EQ  = 6'd4;
  localparam logic [5:0] OP_NE  = 6'd5;
  localparam logic [5:0] OP_LT  = 6'd6;
  localparam logic [5:0] OP_GT  = 6'd7;
  localparam logic [5:0] OP_LE  = 6'd8;
  localparam logic [5:0] OP_GE  = 6'd9;
  localparam logic [5:0] OP_AND = 6'd10;
  localparam logic [5:0] OP_OR  = 6'd11;
  localparam logic [5:0] OP_XOR = 6'd12;
  localparam logic [5:0] OP_SHL = 6'd13;
  localparam logic [5:0] OP_SHR = 6'd14;
  localparam logic [5:0] OP_LD  = 6'd15;
  localparam logic [5:0] OP_ST  = 6'd16;
  localparam logic [5:0] OP_SYS = 6'd63;

  localparam logic [1:0] IOP_JMP = 2'd0;
  localparam logic [1:0] IOP_JNZ = 2'd1;
  localparam logic [1:0] IOP_MVI = 2'd3;

  localparam logic CFG_PROG_SIZE = 1'b0;
  localparam logic CFG_CYC_LIM   = 1'b1;

  // queued request from front to back
  typedef struct packed {
    logic          is_step;
    logic [AW-1:0] addr;
    logic [15:0]   data;
  } req_t;

endpackage
`default_nettype wire

// ===== rtl/core/trc_front.sv =====
`default_nettype none
module trc_front
  import trc_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  input  wire           req_type,
  input  wire  [AW-1:0] mem_addr,
  input  wire  [15:0]   mem_data,
  input  wire           deq,
  output logic          busy,
  output logic          q_valid,
  output req_t          q_head
);

  // two-entry queue of classified requests
  req_t   q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_ptr_r;
  logic       acc;

  // hold off the sender while the queue holds an item
  assign busy = (cnt_r != 2'd0);
  assign acc  = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (acc) cnt_nxt = cnt_nxt + 2'd1;
    if (deq) begin
      cnt_nxt = cnt_nxt - 2'd1;
      rd_nxt = ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      if (acc) wr_ptr_r <= ~wr_ptr_r;
    end
  end

  // store transfer payload into the queue
  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wr_ptr_r].is_step <= req_type;
      q_r[wr_ptr_r].addr    <= mem_addr;
      q_r[wr_ptr_r].data    <= mem_data;
    end
  end

  a_noovf: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue overflow");
  a_deq: assert property (@(posedge clk) disable iff (!rst_n) deq |-> cnt_r != 2'd0)
    else $error("dequeue from empty queue");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n) acc |=> busy)
    else $error("busy not raised after transfer");

endmodule
`default_nettype wire

// ===== rtl/core/trc_back.sv =====
`default_nettype none
module trc_back
  import trc_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_valid,
  input  req_t               q_head,
  output logic               deq,
  input  wire  [PC_W-1:0]    prog_size,
  input  wire  [CYC_W-1:0]   cyc_limit,
  output logic               out_valid,
  output logic [PC_W-1:0]    out_pc_value,
  output logic [1:0]         out_run_status,
  output logic [2:0]         out_sys_event,
  output logic [15:0]        out_sys_value,
  output logic               out_bad_opcode
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_MEM   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } st_t;

  st_t state_r, state_nxt;

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] mrd_r;
  logic [AW-1:0] maddr;
  logic          mwe;
  logic [15:0]   mwd;

  logic [15:0] rf_r [8];
  logic [PC_W-1:0] pc_r;
  logic [CYC_W-1:0] sc_r;
  logic [1:0] hs_r;
  logic [15:0] ir_r, a_r, b_r;
  logic [2:0] ev_r;
  logic [15:0] val_r;
  logic bad_r, exited_r;
  logic exec_r;

  // divider
  logic [15:0] q_r, rem_r;
  logic [4:0]  dcnt_r;
  logic [16:0] rem_sh;

  logic [5:0] op;
  logic [2:0] rd, ra, rb, rr;
  assign op = ir_r[14:9];
  assign rd = ir_r[8:6];
  assign ra = ir_r[5:3];
  assign rb = ir_r[2:0];
  assign rr = ir_r[12:10];

  logic halt_pre;
  assign halt_pre = (hs_r == ST_RUN) &&
                    ((pc_r >= prog_size) || (sc_r >= cyc_limit));

  assign deq = (state_r == S_IDLE) && q_valid;
  assign rem_sh = {rem_r, a_r[15]};

  // memory port: fetch, load, store, write request
  always_comb begin
    mwe = 1'b0;
    mwd = q_head.data;
    maddr = pc_r[AW-1:0];
    if (deq && !q_head.is_step) begin
      mwe = 1'b1;
      maddr = q_head.addr;
    end else if (state_r == S_EXEC) begin
      maddr = a_r[AW-1:0];
      mwd = b_r;
      mwe = !ir_r[15] && (op == OP_ST);
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    mrd_r <= mem[maddr];
  end

  // ALU result for the arithmetic, compare, logic and shift ops
  logic [15:0] alu;
  logic        alu_wr;
  logic [31:0] prod;
  assign prod = a_r * b_r;
  always_comb begin
    alu = 16'd0;
    alu_wr = 1'b1;
    unique case (op)
      OP_ADD: alu = a_r + b_r;
      OP_SUB: alu = a_r - b_r;
      OP_MUL: alu = prod[15:0];
      OP_EQ:  alu = {15'd0, a_r == b_r};
      OP_NE:  alu = {15'd0, a_r != b_r};
      OP_LT:  alu = {15'd0, a_r < b_r};
      OP_GT:  alu = {15'd0, a_r > b_r};
      OP_LE:  alu = {15'd0, a_r <= b_r};
      OP_GE:  alu = {15'd0, a_r >= b_r};
      OP_AND: alu = a_r & b_r;
      OP_OR:  alu = a_r | b_r;
      OP_XOR: alu = a_r ^ b_r;
      OP_SHL: alu = (b_r >= 16'd16) ? 16'd0 : (a_r << b_r[3:0]);
      OP_SHR: alu = (b_r >= 16'd16) ? 16'd0 : (a_r >> b_r[3:0]);
      default: alu_wr = 1'b0;
    endcase
  end

  // post-execution pc and status
  logic [PC_W-1:0] pc_fin;
  logic [CYC_W-1:0] sc_fin;
  logic [1:0] hs_fin;
  logic jumped;
  logic [PC_W-1:0] pc_j;
  always_comb begin
    pc_j = pc_r;
    if (ir_r[15]) begin
      if (ir_r[14:13] == IOP_JMP) pc_j = {1'b0, ir_r[9:0]};
      else if (ir_r[14:13] == IOP_JNZ && rf_r[rr] != 16'd0) pc_j = {1'b0, ir_r[9:0]};
    end
    jumped = (pc_j != pc_r);
    pc_fin = (exited_r || jumped) ? pc_j : pc_r + 1'b1;
    sc_fin = (sc_r == {CYC_W{1'b1}}) ? sc_r : sc_r + 1'b1;
    if (exited_r) hs_fin = ST_EXIT;
    else if (sc_fin >= cyc_limit) hs_fin = ST_LIMIT;
    else if (pc_fin >= prog_size) hs_fin = ST_END;
    else hs_fin = ST_RUN;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (deq) state_nxt = (q_head.is_step && !halt_pre && hs_r == ST_RUN) ?
                                    S_FETCH : S_DONE;
      S_FETCH: state_nxt = S_DEC;
      S_DEC:   state_nxt = (!mrd_r[15] && mrd_r[14:9] == OP_DIV) ? S_DIV : S_EXEC;
      S_DIV:   if (dcnt_r == 5'd16) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = (!ir_r[15] && op == OP_LD) ? S_MEM : S_DONE;
      S_MEM:   state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // track whether the current item executed an instruction
  always_ff @(posedge clk) begin
    if (!rst_n) exec_r <= 1'b0;
    else if (state_r == S_IDLE) exec_r <= 1'b0;
    else if (state_r == S_FETCH) exec_r <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= '0;
      sc_r <= '0;
      hs_r <= ST_RUN;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) rf_r[i] <= 16'd0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE: begin
          ev_r <= EV_NONE; val_r <= 16'd0; bad_r <= 1'b0; exited_r <= 1'b0;
          if (deq && q_head.is_step && halt_pre)
            hs_r <= (pc_r >= prog_size) ? ST_END : ST_LIMIT;
        end
        S_FETCH: ;
        S_DEC: begin
          ir_r <= mrd_r;
          a_r <= rf_r[mrd_r[5:3]];
          b_r <= rf_r[mrd_r[2:0]];
          dcnt_r <= 5'd0;
          q_r <= 16'd0;
          rem_r <= 16'd0;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (dcnt_r != 5'd16) begin
            a_r <= {a_r[14:0], 1'b0};
            if (rem_sh >= {1'b0, b_r}) begin
              rem_r <= 16'(rem_sh - {1'b0, b_r});
              q_r <= {q_r[14:0], 1'b1};
            end else begin
              rem_r <= rem_sh[15:0];
              q_r <= {q_r[14:0], 1'b0};
            end
            dcnt_r <= dcnt_r + 5'd1;
          end
        end
        S_EXEC: begin
          if (ir_r[15]) begin
            if (ir_r[14:13] == IOP_MVI) rf_r[rr] <= {6'd0, ir_r[9:0]};
          end else if (op == OP_LD) begin
          end else if (op == OP_ST) begin
          end else if (op == OP_SYS) begin
            case (rf_r[0])
              16'd0: exited_r <= 1'b1;
              16'd1: begin ev_r <= EV_STR; val_r <= rf_r[1]; end
              16'd2: ev_r <= EV_NL;
              16'd3: begin ev_r <= EV_INT; val_r <= rf_r[1]; end
              default: ev_r <= EV_BAD;
            endcase
          end else if (op == OP_DIV) begin
            rf_r[rd] <= (b_r == 16'd0) ? 16'hFFFF : q_r;
          end else if (alu_wr) begin
            rf_r[rd] <= alu;
          end else begin
            bad_r <= 1'b1;
          end
        end
        S_MEM: rf_r[rd] <= mrd_r;
        S_DONE: begin
          if (exec_r) begin
            pc_r <= pc_fin;
            sc_r <= sc_fin;
            hs_r <= hs_fin;
          end
        end
        default: ;
      endcase
    end
  end

  // result register: one strobe per item
  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_pc_value   <= exec_r ? pc_fin : pc_r;
      out_run_status <= exec_r ? hs_fin : hs_r;
      out_sys_event  <= exec_r ? ev_r : EV_NONE;
      out_sys_value  <= exec_r ? val_r : 16'd0;
      out_bad_opcode <= exec_r && bad_r;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("missing strobe");
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (hs_r != ST_RUN && state_r == S_FETCH) |-> 1'b0) else $error("run while halted");

endmodule
`default_nettype wire

// ===== rtl/core/toy_risc16_core_step.sv =====
`default_nettype none
// toy_risc16_core_step: 16-bit eight-register core with a word-addressed memory.
// Input: pulse start with in_req_type/in_mem_addr/in_mem_data while busy is low.
//   in_req_type 0 writes one memory word, 1 runs one instruction step.
// Output: one result per item, held for one cycle with out_valid high:
//   pc, run status, syscall event and value, bad-opcode flag.
// Config: cfg_we with cfg_index (0 program size, 1 cycle limit) and cfg_data.
// Flow: a memory write, or a step on a halted core, passes from the queue to the done state;
//   a step also runs fetch, decode and execute, a load adds a memory access and a divide
//   adds the back end's divider, which yields one quotient bit per cycle.
//   busy is high only while the front queue holds an item; the next item can
//   be taken while the back end runs the previous one and waits in the queue.
// The front queue holds the transfer; the back end sequences fetch, decode,
//   execute and memory access over the single memory port.
// Reset: registers, pc, step count cleared, status running, program size 0,
//   cycle limit 10000. Memory contents are undefined until written.
// The receiver cannot stall; every result is taken in its strobe cycle.
module toy_risc16_core_step
  import trc_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_req_type,
  input  wire  [9:0]  in_mem_addr,
  input  wire  [15:0] in_mem_data,
  output logic        out_valid,
  output logic [10:0] out_pc_value,
  output logic [1:0]  out_run_status,
  output logic [2:0]  out_sys_event,
  output logic [15:0] out_sys_value,
  output logic        out_bad_opcode,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [13:0] cfg_data
);

  logic [PC_W-1:0]  psize_r;
  logic [CYC_W-1:0] climit_r;
  logic q_valid, deq;
  req_t q_head;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psize_r <= '0;
      climit_r <= CYC_W'(10000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROG_SIZE: psize_r <= cfg_data[PC_W-1:0];
        CFG_CYC_LIM:   climit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  trc_front u_front (
    .clk, .rst_n, .start,
    .req_type(in_req_type), .mem_addr(in_mem_addr), .mem_data(in_mem_data),
    .deq, .busy, .q_valid, .q_head
  );

  trc_back u_back (
    .clk, .rst_n, .q_valid, .q_head, .deq,
    .prog_size(psize_r), .cyc_limit(climit_r),
    .out_valid, .out_pc_value, .out_run_status, .out_sys_event,
    .out_sys_value, .out_bad_opcode
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
module tb;
  import trc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] IOP_NOP = 2'd2;

  typedef struct packed {
    logic [10:0] pc;
    logic [1:0]  status;
    logic [2:0]  event_code;
    logic [15:0] value;
    logic        bad;
  } core_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = 1'b0;
  logic [9:0]  in_mem_addr = '0;
  logic [15:0] in_mem_data = '0;
  logic        out_valid;
  logic [10:0] out_pc_value;
  logic [1:0]  out_run_status;
  logic [2:0]  out_sys_event;
  logic [15:0] out_sys_value;
  logic        out_bad_opcode;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [13:0] cfg_data = '0;

  // shadow copy of the core state
  logic [15:0] gpr [8];
  logic [15:0] mem_image [1024];
  bit          mem_valid [1024];
  logic [10:0] core_pc;
  logic [13:0] step_total;
  logic [1:0]  core_status;
  logic [10:0] prog_words;
  logic [13:0] step_cap;

  core_report_t report_q[$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int steps_sent = 0;
  int idle_pct = 0;
  bit halt_ok = 1'b0;

  toy_risc16_core_step DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_mem_addr(in_mem_addr), .in_mem_data(in_mem_data),
    .out_valid(out_valid), .out_pc_value(out_pc_value), .out_run_status(out_run_status),
    .out_sys_event(out_sys_event), .out_sys_value(out_sys_value),
    .out_bad_opcode(out_bad_opcode),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // compare each result with the oldest expected report
  always @(posedge clk) begin
    core_report_t exp_r;
    if (rst_n && out_valid) begin
      if (report_q.size() == 0) begin
        report_mismatch("result with no transfer pending");
      end else begin
        exp_r = report_q.pop_front();
        if (out_pc_value !== exp_r.pc)
          report_mismatch($sformatf("pc %0d exp %0d", out_pc_value, exp_r.pc));
        if (out_run_status !== exp_r.status)
          report_mismatch($sformatf("status %0d exp %0d", out_run_status, exp_r.status));
        if (out_sys_event !== exp_r.event_code)
          report_mismatch($sformatf("event %0d exp %0d", out_sys_event, exp_r.event_code));
        if (out_sys_value !== exp_r.value)
          report_mismatch($sformatf("value %h exp %h", out_sys_value, exp_r.value));
        if (out_bad_opcode !== exp_r.bad)
          report_mismatch($sformatf("bad %b exp %b", out_bad_opcode, exp_r.bad));
      end
    end
  end

  function automatic logic [15:0] r_word(input logic [5:0] op, input logic [2:0] rd,
                                         input logic [2:0] ra, input logic [2:0] rb);
    return {1'b0, op, rd, ra, rb};
  endfunction

  function automatic logic [15:0] i_word(input logic [1:0] op, input logic [2:0] rr,
                                         input logic [9:0] imm);
    return {1'b1, op, rr, imm};
  endfunction

  // advance the shadow state by one accepted item and queue its report
  task automatic run_core_item(input logic req, input logic [9:0] addr,
                               input logic [15:0] data);
    core_report_t r;
    logic [15:0] w, x, y, res;
    logic [5:0]  op;
    logic [1:0]  iop;
    logic [10:0] old_pc;
    logic        exited, wr;
    r = '0;
    exited = 1'b0;
    if (!req) begin
      mem_image[addr] = data;
      mem_valid[addr] = 1'b1;
    end else begin
      if (core_status == ST_RUN) begin
        if (core_pc >= prog_words) core_status = ST_END;
        else if (step_total >= step_cap) core_status = ST_LIMIT;
      end
      if (core_status == ST_RUN) begin
        old_pc = core_pc;
        w = mem_image[core_pc[9:0]];
        if (!w[15]) begin
          op = w[14:9];
          x = gpr[w[5:3]];
          y = gpr[w[2:0]];
          case (op)
            OP_LD: gpr[w[8:6]] = mem_image[x[9:0]];
            OP_ST: begin
              mem_image[x[9:0]] = y;
              mem_valid[x[9:0]] = 1'b1;
            end
            OP_SYS: begin
              case (gpr[0])
                16'd0: exited = 1'b1;
                16'd1: begin r.event_code = EV_STR; r.value = gpr[1]; end
                16'd2: r.event_code = EV_NL;
                16'd3: begin r.event_code = EV_INT; r.value = gpr[1]; end
                default: r.event_code = EV_BAD;
              endcase
            end
            default: begin
              wr = 1'b1;
              case (op)
                OP_ADD: res = x + y;
                OP_SUB: res = x - y;
                OP_MUL: res = x * y;
                OP_DIV: res = (y == 0) ? 16'hFFFF : x / y;
                OP_EQ:  res = {15'd0, x == y};
                OP_NE:  res = {15'd0, x != y};
                OP_LT:  res = {15'd0, x < y};
                OP_GT:  res = {15'd0, x > y};
                OP_LE:  res = {15'd0, x <= y};
                OP_GE:  res = {15'd0, x >= y};
                OP_AND: res = x & y;
                OP_OR:  res = x | y;
                OP_XOR: res = x ^ y;
                OP_SHL: res = (y >= 16) ? 16'd0 : x << y;
                OP_SHR: res = (y >= 16) ? 16'd0 : x >> y;
                default: begin wr = 1'b0; r.bad = 1'b1; res = '0; end
              endcase
              if (wr) gpr[w[8:6]] = res;
            end
          endcase
        end else begin
          iop = w[14:13];
          case (iop)
            IOP_JMP: core_pc = {1'b0, w[9:0]};
            IOP_JNZ: if (gpr[w[12:10]] != 0) core_pc = {1'b0, w[9:0]};
            IOP_MVI: gpr[w[12:10]] = {6'd0, w[9:0]};
            default: ;
          endcase
        end
        if (!exited && core_pc == old_pc) core_pc = core_pc + 1'b1;
        if (step_total != 14'h3FFF) step_total = step_total + 1'b1;
        if (exited) core_status = ST_EXIT;
        else if (step_total >= step_cap) core_status = ST_LIMIT;
        else if (core_pc >= prog_words) core_status = ST_END;
      end
    end
    r.pc = core_pc;
    r.status = core_status;
    report_q.push_back(r);
  endtask

  // send one item; start stays high until the transfer
  task automatic send_item(input logic req, input logic [9:0] addr, input logic [15:0] data);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_req_type <= req;
    in_mem_addr <= addr;
    in_mem_data <= data;
    do @(posedge clk); while (busy !== 1'b0);
    run_core_item(req, addr, data);
    items_sent++;
    if (req) steps_sent++;
  endtask

  // wait for all reports plus a settle margin
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [13:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PROG_SIZE) prog_words = value[10:0];
    else step_cap = value;
  endtask

  function automatic logic [15:0] random_instr();
    int k;
    k = $urandom_range(99);
    if (k < 50)
      return r_word(6'($urandom_range(16)), 3'($urandom), 3'($urandom), 3'($urandom));
    if (k < 55) return r_word(OP_SYS, 3'($urandom), 3'($urandom), 3'($urandom));
    if (k < 60)
      return r_word(6'($urandom_range(62, 17)), 3'($urandom), 3'($urandom), 3'($urandom));
    if (k < 70) return i_word(IOP_JMP, 3'($urandom), 10'($urandom_range(prog_words - 1)));
    if (k < 80) return i_word(IOP_JNZ, 3'($urandom), 10'($urandom_range(prog_words - 1)));
    if (k < 83) return i_word(IOP_NOP, 3'($urandom), 10'($urandom));
    return i_word(IOP_MVI, 3'($urandom), 10'($urandom));
  endfunction

  // true if the word at the pc would exit or leave the program, unless halt_ok is set
  function automatic bit halts_core(input logic [15:0] w);
    logic [10:0] nxt;
    nxt = core_pc;
    if (halt_ok) return 1'b0;
    if (!w[15]) begin
      if (w[14:9] == OP_SYS && gpr[0] == 0) return 1'b1;
    end else if (w[14:13] == IOP_JMP || (w[14:13] == IOP_JNZ && gpr[w[12:10]] != 0)) begin
      nxt = {1'b0, w[9:0]};
    end
    if (nxt == core_pc) nxt = core_pc + 1'b1;
    return nxt >= prog_words;
  endfunction

  // fill or patch memory so the next step reads only written words, then step
  task automatic step_core();
    logic [15:0] w;
    logic [9:0]  tgt;
    forever begin
      if (core_status != ST_RUN || core_pc >= prog_words || step_total >= step_cap) break;
      if (!mem_valid[core_pc[9:0]]) begin
        send_item(1'b0, core_pc[9:0], random_instr());
        continue;
      end
      w = mem_image[core_pc[9:0]];
      if (halts_core(w)) begin
        do tgt = 10'($urandom_range(prog_words - 1)); while (tgt == core_pc[9:0]);
        send_item(1'b0, core_pc[9:0], i_word(IOP_JMP, 3'($urandom), tgt));
        continue;
      end
      if (!w[15] && w[14:9] == OP_LD && !mem_valid[gpr[w[5:3]][9:0]]) begin
        send_item(1'b0, gpr[w[5:3]][9:0], 16'($urandom));
        continue;
      end
      break;
    end
    send_item(1'b1, 10'($urandom), 16'($urandom));
  endtask

  // hand-written program: move-immediate, divide by zero, shift by 16, syscall, bad opcode, nop, jumps, store and load
  task automatic test_directed();
    logic [15:0] prog [13];
    prog[0]  = i_word(IOP_MVI, 3'd1, 10'd1023);
    prog[1]  = i_word(IOP_MVI, 3'd2, 10'd0);
    prog[2]  = r_word(OP_DIV, 3'd3, 3'd1, 3'd2);
    prog[3]  = i_word(IOP_MVI, 3'd4, 10'd16);
    prog[4]  = r_word(OP_SHL, 3'd5, 3'd1, 3'd4);
    prog[5]  = i_word(IOP_MVI, 3'd0, 10'd3);
    prog[6]  = r_word(OP_SYS, 3'd0, 3'd0, 3'd0);
    prog[7]  = r_word(6'd40, 3'd7, 3'd1, 3'd1);
    prog[8]  = i_word(IOP_NOP, 3'd7, 10'h3FF);
    prog[9]  = i_word(IOP_JMP, 3'd0, 10'd9);
    prog[10] = i_word(IOP_JNZ, 3'd2, 10'd0);
    prog[11] = r_word(OP_ST, 3'd0, 3'd4, 3'd1);
    prog[12] = r_word(OP_LD, 3'd6, 3'd4, 3'd0);
    for (int i = 0; i < 13; i++) send_item(1'b0, 10'(i), prog[i]);
    for (int i = 0; i < 13; i++) step_core();
  endtask

  // random code patches, noise writes and steps, about n items
  task automatic test_random(input int n);
    int k;
    int stop;
    stop = items_sent + n;
    while (items_sent < stop) begin
      k = $urandom_range(99);
      if (k < 10) send_item(1'b0, 10'($urandom), 16'($urandom));
      else if (k < 25)
        send_item(1'b0, 10'(core_pc[9:0] + $urandom_range(8, 1)), random_instr());
      else step_core();
    end
  endtask

  // end the run on a random kind of halt, then poke the halted core
  task automatic test_halt();
    logic [9:0] tgt;
    halt_ok = 1'b1;
    case ($urandom_range(2))
      0: begin
        write_cfg(CFG_PROG_SIZE, 14'd1024);
        tgt = (core_pc == 11'd100) ? 10'd200 : 10'd100;
        send_item(1'b0, core_pc[9:0], i_word(IOP_JMP, 3'd0, tgt));
        step_core();
        send_item(1'b0, tgt, i_word(IOP_MVI, 3'd0, 10'd0));
        send_item(1'b0, tgt + 10'd1, r_word(OP_SYS, 3'd0, 3'd0, 3'd0));
        step_core();
        step_core();
      end
      1: begin
        send_item(1'b0, core_pc[9:0], i_word(IOP_MVI, 3'd2, 10'd5));
        write_cfg(CFG_PROG_SIZE, 14'(core_pc + 1'b1));
        step_core();
      end
      default: begin
        send_item(1'b0, core_pc[9:0], i_word(IOP_MVI, 3'd2, 10'd5));
        write_cfg(CFG_CYC_LIM, step_total + 1'b1);
        step_core();
      end
    endcase
    write_cfg(CFG_PROG_SIZE, 14'd0);
    write_cfg(CFG_CYC_LIM, 14'd0);
    step_core();
    write_cfg(CFG_PROG_SIZE, 14'd1024);
    write_cfg(CFG_CYC_LIM, 14'h3FFF);
    step_core();
    send_item(1'b0, 10'($urandom), 16'($urandom));
    step_core();
  endtask

  initial begin
    int top;
    for (int i = 0; i < 8; i++) gpr[i] = '0;
    for (int i = 0; i < 1024; i++) mem_valid[i] = 1'b0;
    core_pc = '0;
    step_total = '0;
    core_status = ST_RUN;
    prog_words = '0;
    step_cap = 14'd10000;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    write_cfg(CFG_PROG_SIZE, 14'd1024);
    write_cfg(CFG_CYC_LIM, 14'h3FFF);
    test_directed();

    idle_pct = 0;
    test_random(175);

    idle_pct = 53;
    write_cfg(CFG_CYC_LIM, 14'($urandom_range(16383, 3000)));
    test_random(175);

    idle_pct = 22;
    top = (core_pc + 2 > 64) ? core_pc + 2 : 64;
    write_cfg(CFG_PROG_SIZE, 14'((top > 1023) ? 1024 : $urandom_range(1023, top)));
    test_random(175);

    idle_pct = 0;
    write_cfg(CFG_PROG_SIZE, 14'd1024);
    test_random(175);

    test_halt();
    drain();

    $display("sent %0d items (%0d steps), %0d instructions retired, final status %0d",
             items_sent, steps_sent, step_total, core_status);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
